// ----- design/touch_zone_tap_detector_defines.svh -----
// ----------------------------------------------------------------------------
// Touch zone tap detector assertion macros
// Concurrent assertion helpers, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef TOUCH_ZONE_TAP_DETECTOR_DEFINES_SVH
`define TOUCH_ZONE_TAP_DETECTOR_DEFINES_SVH

`ifndef SYNTH
// Checks a property on every rising edge outside of reset.
`define TZD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that a condition implies a consequence on the same edge.
`define TZD_ASSERT_IMPLIES(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);
`else
`define TZD_ASSERT(lbl, prop, msg)
`define TZD_ASSERT_IMPLIES(lbl, cond, cons, msg)
`endif

`endif

// ----- design/tzd_pkg.sv -----
// ----------------------------------------------------------------------------
// Touch zone tap detector package
// Shared constants, codes and structures of the tap detector.
// ----------------------------------------------------------------------------
`default_nettype none

package tzd_pkg;

  localparam int unsigned ZONE_COUNT = 8;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOP_RADIUS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX_TIME = 2'd2;

  // Register reset values. The slop radius is kept as its square.
  localparam logic [23:0] SLOP_SQ_RESET      = 24'd400;
  localparam logic [31:0] TAP_MAX_TIME_RESET = 32'd250000;

  // Phase codes.
  localparam logic [1:0] PHASE_IDLE        = 2'd0;
  localparam logic [1:0] PHASE_PENDING     = 2'd1;
  localparam logic [1:0] PHASE_PASSTHROUGH = 2'd2;

  // Decision codes.
  localparam logic [1:0] DEC_PASS     = 2'd0;
  localparam logic [1:0] DEC_SUPPRESS = 2'd1;
  localparam logic [1:0] DEC_TRIGGER  = 2'd2;

  typedef struct packed {
    logic signed [4:0] zone_id;
    logic signed [4:0] fingers;
    logic [11:0]       pos_x;
    logic [11:0]       pos_y;
    logic [47:0]       timestamp;
  } tzd_item_t;

  typedef struct packed {
    logic [1:0] decision;
    logic [3:0] hit_zone;
  } tzd_result_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [3:0]  pending_zone;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [47:0] origin_time;
  } tzd_state_t;

  typedef struct packed {
    logic        enable;
    logic [23:0] slop_sq;
    logic [31:0] tap_max_time;
  } tzd_cfg_t;

  localparam tzd_state_t STATE_CLEAR = '{default: '0};

endpackage

`default_nettype wire

// ----- design/tzd_step.sv -----
// ----------------------------------------------------------------------------
// Touch zone tap detector step logic
// Computes the decision for one touch report and the next gesture state.
// ----------------------------------------------------------------------------
`default_nettype none

module tzd_step (
  input  tzd_pkg::tzd_state_t  state_i,
  input  tzd_pkg::tzd_item_t   item_i,
  input  tzd_pkg::tzd_cfg_t    cfg_i,
  output tzd_pkg::tzd_state_t  state_o,
  output tzd_pkg::tzd_result_t result_o
);
  import tzd_pkg::*;

  logic               fingers_none;
  logic               fingers_one;
  logic               zone_valid;
  logic [47:0]        elapsed;
  logic               in_time;
  logic signed [12:0] dx;
  logic signed [12:0] dy;
  logic [25:0]        dx_sq;
  logic [25:0]        dy_sq;
  logic [26:0]        dist_sq;
  logic               beyond_slop;

  // A negative finger count counts as no finger.
  assign fingers_none = item_i.fingers[4] || (item_i.fingers == 5'sd0);
  assign fingers_one  = (item_i.fingers == 5'sd1);
  assign zone_valid   = !item_i.zone_id[4] &&
                        ({1'b0, item_i.zone_id[3:0]} < 5'(ZONE_COUNT));

  // Elapsed time wraps modulo 2^48; the limit itself is still in time.
  assign elapsed = item_i.timestamp - state_i.origin_time;
  assign in_time = (elapsed <= {16'b0, cfg_i.tap_max_time});

  // The squares are formed at full width so large movements do not wrap.
  assign dx      = $signed({1'b0, item_i.pos_x}) - $signed({1'b0, state_i.origin_x});
  assign dy      = $signed({1'b0, item_i.pos_y}) - $signed({1'b0, state_i.origin_y});
  assign dx_sq   = $unsigned(26'(dx) * 26'(dx));
  assign dy_sq   = $unsigned(26'(dy) * 26'(dy));
  assign dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};
  assign beyond_slop = (dist_sq > {3'b0, cfg_i.slop_sq});

  always_comb begin
    state_o           = state_i;
    result_o.decision = DEC_PASS;
    result_o.hit_zone = 4'd0;
    if (!cfg_i.enable) begin
      state_o = STATE_CLEAR;
    end else begin
      case (state_i.phase)
        PHASE_IDLE: begin
          if (fingers_one && zone_valid) begin
            state_o.phase        = PHASE_PENDING;
            state_o.pending_zone = item_i.zone_id[3:0];
            state_o.origin_x     = item_i.pos_x;
            state_o.origin_y     = item_i.pos_y;
            state_o.origin_time  = item_i.timestamp;
            result_o.decision    = DEC_SUPPRESS;
          end else if (!fingers_none) begin
            state_o.phase = PHASE_PASSTHROUGH;
          end
        end
        PHASE_PENDING: begin
          if (fingers_none) begin
            state_o = STATE_CLEAR;
            if (in_time) begin
              result_o.decision = DEC_TRIGGER;
              result_o.hit_zone = state_i.pending_zone;
            end
          end else if (!fingers_one || !in_time || beyond_slop) begin
            state_o.phase        = PHASE_PASSTHROUGH;
            state_o.pending_zone = 4'd0;
          end else begin
            result_o.decision = DEC_SUPPRESS;
          end
        end
        PHASE_PASSTHROUGH: begin
          if (fingers_none) begin
            state_o = STATE_CLEAR;
          end
        end
        default: begin
          state_o = STATE_CLEAR;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/touch_zone_tap_detector.sv -----
// ----------------------------------------------------------------------------
// Touch zone tap detector
// Recognizes single-finger taps on touch zones from a stream of touch reports.
// ----------------------------------------------------------------------------
// Each accepted touch report produces exactly one decision (pass, suppress or
// tap triggered with its zone). The block accepts one report per clock cycle
// while the consumer does not stall; a report is registered on acceptance,
// its decision is computed combinationally from that input register and the
// gesture state, and it is held in an output register once that register
// frees up. While the consumer stalls, the input register takes at most one
// more report and the input side then stalls as well. Write the
// configuration registers only while no report is in flight.
`default_nettype none
`include "touch_zone_tap_detector_defines.svh"

module touch_zone_tap_detector (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tzd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [tzd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [4:0]                 zone_id_i,
  input  wire logic signed [4:0]                 fingers_i,
  input  wire logic [11:0]                       pos_x_i,
  input  wire logic [11:0]                       pos_y_i,
  input  wire logic [47:0]                       timestamp_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [1:0]                             decision_o,
  output logic [3:0]                             hit_zone_o
);
  import tzd_pkg::*;

  tzd_cfg_t    cfg_q;
  logic [23:0] slop_sq_d;

  logic        s1_valid_q;
  tzd_item_t   s1_item_q;
  logic        s2_valid_q;
  tzd_result_t s2_res_q;
  tzd_state_t  state_q;
  tzd_state_t  state_d;
  tzd_result_t res_d;
  logic        s1_advance;
  logic        in_fire;

  assign slop_sq_d = {12'b0, cfg_data_i[11:0]} * {12'b0, cfg_data_i[11:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable       <= 1'b1;
      cfg_q.slop_sq      <= SLOP_SQ_RESET;
      cfg_q.tap_max_time <= TAP_MAX_TIME_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ENABLE:       cfg_q.enable       <= cfg_data_i[0];
        CFG_SLOP_RADIUS:  cfg_q.slop_sq      <= slop_sq_d;
        CFG_TAP_MAX_TIME: cfg_q.tap_max_time <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  // The result register frees up when empty or when its transaction completes.
  assign s1_advance = !s2_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.zone_id   <= zone_id_i;
      s1_item_q.fingers   <= fingers_i;
      s1_item_q.pos_x     <= pos_x_i;
      s1_item_q.pos_y     <= pos_y_i;
      s1_item_q.timestamp <= timestamp_i;
    end
  end

  tzd_step u_step (
    .state_i  (state_q),
    .item_i   (s1_item_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= STATE_CLEAR;
      s2_valid_q <= 1'b0;
    end else if (s1_advance) begin
      s2_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && s1_valid_q) begin
      s2_res_q <= res_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign decision_o  = s2_res_q.decision;
  assign hit_zone_o  = s2_res_q.hit_zone;

  `TZD_ASSERT_IMPLIES(a_hit_only_on_trigger, out_valid_o && (decision_o != DEC_TRIGGER), hit_zone_o == 4'd0, "hit zone set without a triggered tap")
  `TZD_ASSERT_IMPLIES(a_zone_only_pending, state_q.pending_zone != 4'd0, state_q.phase == PHASE_PENDING, "pending zone held outside a pending tap")
  `TZD_ASSERT_IMPLIES(a_ready_when_drained, out_ready_i, in_ready_o, "input stalled while the output side drains")
  `TZD_ASSERT(a_suppress_keeps_pending, (s1_valid_q && s1_advance && (res_d.decision == DEC_SUPPRESS)) |=> (state_q.phase == PHASE_PENDING), "suppressed report did not leave a pending tap")

endmodule

`default_nettype wire

// ----- sim/tb_touch_zone_tap_detector.sv -----
// ----------------------------------------------------------------------------
// Touch zone tap detector testbench
// Drives touch reports through the valid/ready input channel and checks every
// decision against a cycle-free behavioral predictor kept in the testbench, or
// against the table's decision for directed rows that give one. The directed
// table covers slop and time boundaries and zone and finger corner cases. Random
// phases run well-formed taps and swipes with noise under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_touch_zone_tap_detector;
  import tzd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned MAX_PRINTED = 40;

  typedef struct {
    logic signed [4:0] zone;
    logic signed [4:0] fing;
    logic [11:0]       x;
    logic [11:0]       y;
    logic [47:0]       ts;
    bit                typed;
    logic [1:0]        dec;
    logic [3:0]        hit;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic signed [4:0]     zone_id_i;
  logic signed [4:0]     fingers_i;
  logic [11:0]           pos_x_i;
  logic [11:0]           pos_y_i;
  logic [47:0]           timestamp_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [1:0]            decision_o;
  logic [3:0]            hit_zone_o;

  // Gesture state and register copies of the predictor.
  logic [1:0]  g_phase;
  logic [3:0]  g_zone;
  logic [11:0] g_x0;
  logic [11:0] g_y0;
  logic [47:0] g_t0;
  logic        cf_en;
  logic [11:0] cf_slop;
  logic [31:0] cf_tmax;

  tzd_result_t awaited_decisions[$];
  dir_row_t    dir_tab[26];
  int unsigned err_count;
  int unsigned reports_sent;
  int unsigned idle_cycles;
  int unsigned stall_left;
  bit          tx_quiet;
  bit          rx_quiet;

  touch_zone_tap_detector DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .zone_id_i   (zone_id_i),
    .fingers_i   (fingers_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .timestamp_i (timestamp_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .decision_o  (decision_o),
    .hit_zone_o  (hit_zone_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  function automatic void clear_gesture();
    g_phase = PHASE_IDLE;
    g_zone  = '0;
    g_x0    = '0;
    g_y0    = '0;
    g_t0    = '0;
  endfunction

  // Computes the decision for one report and advances the gesture state.
  function automatic tzd_result_t classify_touch(input tzd_item_t it);
    tzd_result_t res;
    int          zn;
    int          nf;
    logic [47:0] elapsed;
    longint      dx;
    longint      dy;
    bit          too_far;
    res = '{decision: DEC_PASS, hit_zone: 4'd0};
    zn = it.zone_id;
    nf = it.fingers;
    if (nf < 0) nf = 0;
    elapsed = it.timestamp - g_t0;
    dx = longint'(it.pos_x) - longint'(g_x0);
    dy = longint'(it.pos_y) - longint'(g_y0);
    too_far = (dx * dx + dy * dy) > (longint'(cf_slop) * longint'(cf_slop));
    if (!cf_en) begin
      clear_gesture();
    end else begin
      case (g_phase)
        PHASE_IDLE: begin
          if (nf == 1 && zn >= 0 && zn < int'(ZONE_COUNT)) begin
            g_phase = PHASE_PENDING;
            g_zone  = it.zone_id[3:0];
            g_x0    = it.pos_x;
            g_y0    = it.pos_y;
            g_t0    = it.timestamp;
            res.decision = DEC_SUPPRESS;
          end else if (nf != 0) begin
            g_phase = PHASE_PASSTHROUGH;
          end
        end
        PHASE_PENDING: begin
          if (nf == 0) begin
            // The tap fires only if the finger lifts within the time limit.
            if (elapsed <= {16'd0, cf_tmax}) begin
              res.decision = DEC_TRIGGER;
              res.hit_zone = g_zone;
            end
            clear_gesture();
          end else if (nf != 1 || elapsed > {16'd0, cf_tmax} || too_far) begin
            g_phase = PHASE_PASSTHROUGH;
            g_zone  = '0;
          end else begin
            res.decision = DEC_SUPPRESS;
          end
        end
        PHASE_PASSTHROUGH: begin
          if (nf == 0) clear_gesture();
        end
        default: begin
          clear_gesture();
        end
      endcase
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (quiet || sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Time since touch-down: mostly inside the limit, often right at its edge.
  function automatic logic [47:0] pick_elapsed();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 48'($urandom_range(0, cf_tmax >> 1));
    if (sel < 8) return {16'd0, cf_tmax} + 48'($urandom_range(0, 2)) - 48'd1;
    if (sel == 8) return 48'({$urandom, $urandom});
    return '0;
  endfunction

  function automatic tzd_item_t random_report();
    tzd_item_t it;
    it.zone_id   = 5'($urandom);
    it.fingers   = 5'($urandom);
    it.pos_x     = 12'($urandom);
    it.pos_y     = 12'($urandom);
    it.timestamp = 48'({$urandom, $urandom});
    return it;
  endfunction

  task automatic drive_report(input tzd_item_t it, input bit typed = 1'b0,
                              input tzd_result_t typed_res = '0);
    int unsigned gap;
    tzd_result_t res;
    gap = pick_gap(tx_quiet);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    zone_id_i   <= it.zone_id;
    fingers_i   <= it.fingers;
    pos_x_i     <= it.pos_x;
    pos_y_i     <= it.pos_y;
    timestamp_i <= it.timestamp;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    res = classify_touch(it);
    awaited_decisions.push_back(typed ? typed_res : res);
    reports_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_decisions.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_ENABLE:       cf_en = data[0];
      CFG_SLOP_RADIUS:  cf_slop = data[11:0];
      CFG_TAP_MAX_TIME: cf_tmax = data;
      default: ;
    endcase
  endtask

  // Unused data bits are randomized; the block must ignore them.
  task automatic set_registers(input bit en, input logic [11:0] slop,
                               input logic [31:0] tmax);
    logic [31:0] data;
    data = $urandom;
    data[0] = en;
    write_reg(CFG_ENABLE, data);
    data = $urandom;
    data[11:0] = slop;
    write_reg(CFG_SLOP_RADIUS, data);
    write_reg(CFG_TAP_MAX_TIME, tmax);
    write_reg(CFG_IDX_UNUSED, $urandom);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic tap_gesture();
    tzd_item_t   it;
    logic [47:0] t0;
    logic [11:0] x0;
    logic [11:0] y0;
    int unsigned span;
    t0 = 48'({$urandom, $urandom});
    x0 = 12'($urandom);
    y0 = 12'($urandom);
    span = ((cf_slop > 60) ? 60 : cf_slop) + 3;
    it.zone_id = ($urandom_range(0, 7) != 0) ? 5'($urandom_range(0, ZONE_COUNT - 1))
                                             : 5'($urandom);
    it.fingers = ($urandom_range(0, 9) != 0) ? 5'sd1 : 5'($urandom);
    it.pos_x = x0;
    it.pos_y = y0;
    it.timestamp = t0;
    drive_report(it);
    repeat ($urandom_range(0, 3)) begin
      it.zone_id = 5'($urandom);
      it.fingers = ($urandom_range(0, 7) != 0) ? 5'sd1 : 5'($urandom_range(2, 15));
      if ($urandom_range(0, 5) == 0) begin
        it.pos_x = 12'($urandom);
        it.pos_y = 12'($urandom);
      end else begin
        it.pos_x = x0 + 12'($urandom_range(0, 2 * span)) - 12'(span);
        it.pos_y = y0 + 12'($urandom_range(0, 2 * span)) - 12'(span);
      end
      it.timestamp = t0 + pick_elapsed();
      drive_report(it);
    end
    // Lift: zero or a negative count, which also means no finger.
    it.zone_id = 5'($urandom);
    it.fingers = $urandom_range(0, 1) ? 5'sd0 : 5'($urandom_range(16, 31));
    it.pos_x = 12'($urandom);
    it.pos_y = 12'($urandom);
    it.timestamp = t0 + pick_elapsed();
    drive_report(it);
  endtask

  task automatic swipe_gesture();
    tzd_item_t it;
    repeat ($urandom_range(1, 3)) begin
      it = random_report();
      it.fingers = 5'($urandom_range(2, 15));
      drive_report(it);
    end
    it = random_report();
    it.fingers = 5'sd0;
    drive_report(it);
  endtask

  task automatic run_phase(input bit en, input logic [11:0] slop,
                           input logic [31:0] tmax, input int unsigned count);
    int unsigned goal;
    int unsigned sel;
    wait_drained();
    set_registers(en, slop, tmax);
    tx_quiet = ($urandom_range(0, 3) == 0);
    rx_quiet = ($urandom_range(0, 3) == 0);
    goal = reports_sent + count;
    while (reports_sent < goal) begin
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
        repeat ($urandom_range(1, 4)) drive_report(random_report());
      end else if (sel < 8) begin
        tap_gesture();
      end else begin
        swipe_gesture();
      end
    end
  endtask

  // Result side: random stalls, checked against the oldest awaited decision.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if (!rx_quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap(1'b0);
    end
  end

  always @(posedge clk_i) begin : result_check
    tzd_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_decisions.size() == 0) begin
        report_mismatch($sformatf("decision %0d zone %0d with no report outstanding",
                                  decision_o, hit_zone_o));
      end else begin
        want = awaited_decisions.pop_front();
        if (decision_o !== want.decision)
          report_mismatch($sformatf("decision %0d, want %0d", decision_o, want.decision));
        if (hit_zone_o !== want.hit_zone)
          report_mismatch($sformatf("hit_zone %0d, want %0d", hit_zone_o, want.hit_zone));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    zone_id_i   = '0;
    fingers_i   = '0;
    pos_x_i     = '0;
    pos_y_i     = '0;
    timestamp_i = '0;
    out_ready_i = 1'b0;
    err_count    = 0;
    reports_sent = 0;
    idle_cycles  = 0;
    stall_left   = 0;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;
    cf_en   = 1'b1;
    cf_slop = 12'd20;
    cf_tmax = 32'd250000;
    clear_gesture();

    // Defaults after reset: slop 20 pixels, limit 250000 us.
    dir_tab = '{
      '{3, 1, 100, 100, 1000, 1'b1, DEC_SUPPRESS, 0},
      '{3, 1, 112, 116, 2000, 1'b1, DEC_SUPPRESS, 0},    // exactly on the slop circle
      '{3, 0, 0, 0, 251000, 1'b1, DEC_TRIGGER, 3},       // lift exactly at the limit
      '{-1, 1, 5, 5, 300000, 1'b1, DEC_PASS, 0},         // no zone
      '{5, 1, 5, 5, 300010, 1'b1, DEC_PASS, 0},
      '{0, 0, 0, 0, 300020, 1'b1, DEC_PASS, 0},
      '{8, 1, 9, 9, 300030, 1'b1, DEC_PASS, 0},          // zone beyond the zone count
      '{2, -8, 9, 9, 300040, 1'b1, DEC_PASS, 0},
      '{15, 15, 4095, 4095, 300050, 1'b1, DEC_PASS, 0},
      '{-16, 0, 0, 0, 300060, 1'b1, DEC_PASS, 0},
      '{7, 1, 4095, 4095, 48'hFFFF_FFFF_FF9C, 1'b0, DEC_PASS, 0},
      '{7, 1, 4095, 4095, 50, 1'b0, DEC_PASS, 0},        // time wraps past zero
      '{7, -1, 0, 0, 60, 1'b1, DEC_TRIGGER, 7},
      '{0, 1, 0, 0, 10, 1'b1, DEC_SUPPRESS, 0},
      '{0, 1, 13, 17, 20, 1'b0, DEC_PASS, 0},            // just outside the slop
      '{0, 0, 0, 0, 30, 1'b1, DEC_PASS, 0},
      '{2, 1, 50, 50, 0, 1'b1, DEC_SUPPRESS, 0},
      '{2, 2, 50, 50, 5, 1'b0, DEC_PASS, 0},             // second finger lands
      '{2, 0, 50, 50, 9, 1'b1, DEC_PASS, 0},
      '{1, 1, 0, 0, 0, 1'b1, DEC_SUPPRESS, 0},
      '{1, 1, 0, 0, 250001, 1'b0, DEC_PASS, 0},          // held too long
      '{1, 0, 0, 0, 250002, 1'b1, DEC_PASS, 0},
      '{4, 1, 0, 0, 1000, 1'b1, DEC_SUPPRESS, 0},
      '{4, 0, 0, 0, 251001, 1'b1, DEC_PASS, 0},          // late lift
      '{6, 1, 4095, 0, 500000, 1'b1, DEC_SUPPRESS, 0},
      '{6, 0, 0, 4095, 500100, 1'b1, DEC_TRIGGER, 6}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      drive_report('{zone_id: dir_tab[i].zone, fingers: dir_tab[i].fing,
                     pos_x: dir_tab[i].x, pos_y: dir_tab[i].y,
                     timestamp: dir_tab[i].ts},
                   dir_tab[i].typed,
                   '{decision: dir_tab[i].dec, hit_zone: dir_tab[i].hit});
    end

    run_phase(1'b1, 12'd20, 32'd250000, 150);
    run_phase(1'b1, 12'd0, 32'd0, 150);
    run_phase(1'b1, 12'd4095, 32'hFFFF_FFFF, 150);
    run_phase(1'b0, 12'($urandom), $urandom, 120);
    run_phase(1'b1, 12'($urandom_range(1, 100)), $urandom_range(100, 5000), 200);
    run_phase(1'b1, 12'($urandom), $urandom, 160);

    wait_drained();
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
